### src/bis_pkg.sv
// Package for the bounded integer stack: sizes, operation codes,
// controller states and the beat structs shared by all modules but bis_ram.
// No dependencies.
`default_nettype none

package bis_pkg;

  // Storage geometry
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W  = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned OP_W    = 3;

  // Operation codes carried by an input beat
  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_PEEK      = 3'd2,
    OP_DUMP_DOWN = 3'd3,
    OP_DUMP_UP   = 3'd4
  } op_e;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  // Input beat
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] push_value;
  } in_t;

  // Result beat
  typedef struct packed {
    logic signed [WORD_W-1:0] item_value;
    logic                     last_of_run;
  } out_t;

  // Memory access request from controller to entry store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

### src/bounded_integer_stack.sv
// Channel    | Ports                          | Beat accepted when
// -----------+--------------------------------+---------------------------------
// command    | start_i, busy_o, in_i          | start_i high and busy_o low
// result     | res_valid_o, res_o             | every cycle res_valid_o is high
// capacity   | cfg_we_i, cfg_wdata_i          | every cycle cfg_we_i is high
//
// Push and pop may follow back to back.
// Peek shows its word in the cycle after acceptance, without raising busy_o.
// A dump holds busy_o until its last entry-store read, one read per
// cycle; its words appear back to back, the first in the cycle after
// acceptance. The single read port of the entry store sets this pace.
// Reset empties the stack and sets capacity to 64; no clearing pass runs.
// The receiver cannot stall: each result is valid for exactly one cycle.
//
// Top level: bounded LIFO stack. Depends on bis_pkg, bis_ctrl, bis_ram.
`default_nettype none

module bounded_integer_stack (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire bis_pkg::in_t              in_i,
  output logic                           busy_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bis_pkg::CAP_W-1:0] cfg_wdata_i,
  output logic                           res_valid_o,
  output bis_pkg::out_t                  res_o
);

  bis_pkg::mem_req_t           mem_req;
  logic [bis_pkg::WORD_W-1:0]  rdata;
  logic                        rd_last;

  // Control and sequencing
  bis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (busy_o),
    .mem_o       (mem_req),
    .rd_vld_o    (res_valid_o),
    .rd_last_o   (rd_last)
  );

  // Entry store
  bis_ram #(
    .DEPTH  (bis_pkg::DEPTH),
    .WIDTH  (bis_pkg::WORD_W),
    .ADDR_W (bis_pkg::ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // Assemble the result beat from the registered read data
  assign res_o.item_value  = rdata;
  assign res_o.last_of_run = rd_last;

endmodule

`default_nettype wire

### src/bis_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module bis_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/bis_ctrl.sv
// Stack controller: fill count, capacity register, operation decode and
// the dump sequencer that walks the entry store. Depends on bis_pkg.
`default_nettype none

module bis_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire bis_pkg::in_t                   in_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [bis_pkg::CAP_W-1:0]      cfg_wdata_i,
  output logic                                busy_o,
  output bis_pkg::mem_req_t                   mem_o,
  output logic                                rd_vld_o,
  output logic                                rd_last_o
);

  bis_pkg::state_e                    state_q, state_d;
  logic [bis_pkg::FILL_W-1:0]         fill_q, fill_d;
  logic [bis_pkg::CAP_W-1:0]          cap_q;
  logic [bis_pkg::ADDR_W-1:0]         idx_q, idx_d;
  logic                               down_q, down_d;
  logic                               rvld_q, rvld_d;
  logic                               rlast_q, rlast_d;

  logic                               accept;
  logic [bis_pkg::CAP_W-1:0]          eff_cap;
  logic [bis_pkg::FILL_W-1:0]         fill_m1;
  logic [bis_pkg::ADDR_W-1:0]         top_idx;
  logic                               at_end;

  assign busy_o  = (state_q == bis_pkg::ST_DUMP);
  assign accept  = start_i && !busy_o;

  // Clamp capacity to the physical depth
  assign eff_cap = (cap_q > bis_pkg::CAP_W'(bis_pkg::DEPTH)) ?
                   bis_pkg::CAP_W'(bis_pkg::DEPTH) : cap_q;

  assign fill_m1 = fill_q - bis_pkg::FILL_W'(1);
  assign top_idx = fill_m1[bis_pkg::ADDR_W-1:0];
  assign at_end  = down_q ? (idx_q == '0) : (idx_q == top_idx);

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bis_pkg::CAP_W'(bis_pkg::DEPTH);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // State, fill count, sequencer and read-tag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bis_pkg::ST_IDLE;
      fill_q  <= '0;
      idx_q   <= '0;
      down_q  <= 1'b0;
      rvld_q  <= 1'b0;
      rlast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      down_q  <= down_d;
      rvld_q  <= rvld_d;
      rlast_q <= rlast_d;
    end
  end

  // Decode operations and step the dump sequencer. A write and a read never
  // fall in the same cycle, and a push completes at its edge, so a read in
  // any later cycle already sees the new word: no forwarding is needed.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    down_d      = down_q;
    rvld_d      = 1'b0;
    rlast_d     = 1'b0;
    mem_o.we    = 1'b0;
    mem_o.waddr = fill_q[bis_pkg::ADDR_W-1:0];
    mem_o.wdata = in_i.push_value;
    mem_o.raddr = idx_q;

    unique case (state_q)
      bis_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (bis_pkg::op_e'(in_i.operation))
            bis_pkg::OP_PUSH: begin
              // Drop the beat when the stack is full
              if (bis_pkg::CAP_W'(fill_q) < eff_cap) begin
                mem_o.we = 1'b1;
                fill_d   = fill_q + bis_pkg::FILL_W'(1);
              end
            end
            bis_pkg::OP_POP: begin
              if (fill_q != '0) begin
                fill_d = fill_m1;
              end
            end
            bis_pkg::OP_PEEK: begin
              if (fill_q != '0) begin
                mem_o.raddr = top_idx;
                rvld_d      = 1'b1;
                rlast_d     = 1'b1;
              end
            end
            bis_pkg::OP_DUMP_DOWN: begin
              if (fill_q != '0) begin
                mem_o.raddr = top_idx;
                rvld_d      = 1'b1;
                if (top_idx == '0) begin
                  rlast_d = 1'b1;
                end else begin
                  state_d = bis_pkg::ST_DUMP;
                  down_d  = 1'b1;
                  idx_d   = top_idx - bis_pkg::ADDR_W'(1);
                end
              end
            end
            bis_pkg::OP_DUMP_UP: begin
              if (fill_q != '0) begin
                mem_o.raddr = '0;
                rvld_d      = 1'b1;
                if (fill_q == bis_pkg::FILL_W'(1)) begin
                  rlast_d = 1'b1;
                end else begin
                  state_d = bis_pkg::ST_DUMP;
                  down_d  = 1'b0;
                  idx_d   = bis_pkg::ADDR_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      bis_pkg::ST_DUMP: begin
        // Read one entry per cycle until the far end
        mem_o.raddr = idx_q;
        rvld_d      = 1'b1;
        if (at_end) begin
          rlast_d = 1'b1;
          state_d = bis_pkg::ST_IDLE;
        end else begin
          idx_d = down_q ? (idx_q - bis_pkg::ADDR_W'(1)) : (idx_q + bis_pkg::ADDR_W'(1));
        end
      end
      default: begin
        state_d = bis_pkg::ST_IDLE;
      end
    endcase
  end

  assign rd_vld_o  = rvld_q;
  assign rd_last_o = rlast_q;

endmodule

`default_nettype wire

### src/bis_checker.sv
// Port-level checker for the bounded integer stack, bound to the top level.
// Depends on bis_pkg and bounded_integer_stack.
`default_nettype none

module bis_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire logic          busy_o,
  input wire logic          res_valid_o,
  input wire bis_pkg::out_t res_o
);

  // Busy only starts on an accepted command beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && !busy_o))
    else $error("busy rose without an accepted command");

  // A dump in progress delivers a word on the next cycle
  a_dump_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> res_valid_o)
    else $error("dump cycle not followed by a result beat");

  // A word that is not the last of its run means the dump is still going
  a_mid_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_of_run) |-> busy_o)
    else $error("non-final result beat while idle");

  // Leaving a dump coincides with its final word
  a_end_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (res_valid_o && res_o.last_of_run))
    else $error("dump ended without a final result beat");

endmodule

bind bounded_integer_stack bis_checker u_bis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire
